// ----- rtl/pvl_pkg.sv -----
// ----------------------------------------------------------------------------
// pvl_pkg: shared types and constants for particle vertex lighting
// Field widths, pipeline depths, register codes and the light table entry.
// ----------------------------------------------------------------------------
`default_nettype none

package pvl_pkg;

  localparam int LAMP_SLOTS = 6;

  localparam int SLOT_W  = 3;
  localparam int POS_W   = 32;
  localparam int DIR_W   = 16;
  localparam int REACH_W = 40;
  localparam int COS_W   = 16;
  localparam int RGB_W   = 48;
  localparam int CLR_W   = 32;
  localparam int AMB_W   = 15;
  localparam int ACT_W   = 3;
  localparam int TDATA_W = 288;

  localparam int PROD_W = 31;  // Q4.12 color times Q.14 falloff
  localparam int ACC_W  = 34;  // ambient plus all light terms

  localparam int ATT_STEPS   = 15;
  localparam int SQRT_STEPS  = 28;
  localparam int DIV_C_STEPS = 15;
  localparam int FADE_STEPS  = 15;

  // lane: 4 front stages, sqrt, cone quotient (+1 range check), decide,
  // fade quotient, two multiply stages
  localparam int LANE_LAT = 4 + SQRT_STEPS + 1 + DIV_C_STEPS + 1 + FADE_STEPS + 2;
  // lane plus light sum and gain clamp
  localparam int PIPE_D = LANE_LAT + 2;

  localparam logic [AMB_W-1:0]        UNITY     = 15'd16384;
  localparam logic signed [DIR_W-1:0] DIR_DEF_Y = -16'sd16384;

  typedef enum logic [0:0] {
    CFG_AMBIENT = 1'b0,
    CFG_ACTIVE  = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    ACT_SHADE = 1'b0,
    ACT_LOAD  = 1'b1
  } action_e;

  typedef struct packed {
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
    logic signed [DIR_W-1:0]   dir_x;
    logic signed [DIR_W-1:0]   dir_y;
    logic signed [DIR_W-1:0]   dir_z;
    logic        [REACH_W-1:0] reach_sq;
    logic signed [COS_W-1:0]   cone_cos;
    logic        [RGB_W-1:0]   rgb;
  } lamp_t;

endpackage

`default_nettype wire

// ----- rtl/pvl_table.sv -----
// ----------------------------------------------------------------------------
// pvl_table: light table
// One register entry per light slot, written by load transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module pvl_table (
  input  wire                                       clk_i,
  input  wire                                       we_i,
  input  wire  [pvl_pkg::SLOT_W-1:0]                slot_i,
  input  pvl_pkg::lamp_t                            lamp_i,
  output pvl_pkg::lamp_t [pvl_pkg::LAMP_SLOTS-1:0]  lamps_o
);
  import pvl_pkg::*;

  lamp_t [LAMP_SLOTS-1:0] lamp_q;
  lamp_t                  lamp_d;

  // a zero direction defaults to straight down
  always_comb begin
    lamp_d = lamp_i;
    if (lamp_i.dir_x == '0 && lamp_i.dir_y == '0 && lamp_i.dir_z == '0) begin
      lamp_d.dir_y = DIR_DEF_Y;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LAMP_SLOTS; i++) begin
      if (we_i && int'(slot_i) == i) begin
        lamp_q[i] <= lamp_d;
      end
    end
  end

  assign lamps_o = lamp_q;

endmodule

`default_nettype wire

// ----- rtl/pvl_lane.sv -----
// ----------------------------------------------------------------------------
// pvl_lane: per-light shading pipeline
// Distance, falloff quotient, distance root, cone quotient, cone fade and the
// weighted color of one light, one step per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pvl_lane (
  input  wire                                        clk_i,
  input  wire                                        adv_i,
  input  wire                                        act_i,
  input  wire  signed [pvl_pkg::POS_W-1:0]           px_i,
  input  wire  signed [pvl_pkg::POS_W-1:0]           py_i,
  input  wire  signed [pvl_pkg::POS_W-1:0]           pz_i,
  input  pvl_pkg::lamp_t                             lamp_i,
  output logic [2:0][pvl_pkg::PROD_W-1:0]            prod_o
);
  import pvl_pkg::*;

  typedef struct packed {
    logic                      act;
    logic        [REACH_W-1:0] reach;
    logic signed [COS_W-1:0]   cc;
    logic        [RGB_W-1:0]   rgb;
  } carry_t;

  typedef struct packed {
    logic                      live;
    logic                      spot;
    logic signed [COS_W-1:0]   cc;
    logic        [RGB_W-1:0]   rgb;
    logic        [REACH_W-1:0] reach;
    logic        [REACH_W-1:0] arem;
    logic        [14:0]        aq;
    logic        [55:0]        sv;
    logic        [56:0]        sr;
    logic        [50:0]        dmag;
    logic                      dneg;
  } a_t;

  typedef struct packed {
    logic                      live;
    logic                      spot;
    logic signed [COS_W-1:0]   cc;
    logic        [RGB_W-1:0]   rgb;
    logic        [14:0]        att;
    logic        [27:0]        d;
    logic        [50:0]        brem;
    logic        [14:0]        bq;
    logic                      sat;
    logic                      dneg;
  } b_t;

  typedef struct packed {
    logic               live;
    logic               use_cone;
    logic [RGB_W-1:0]   rgb;
    logic [14:0]        att;
    logic [15:0]        frem;
    logic [15:0]        fden;
    logic [14:0]        fq;
  } c_t;

  // front stages
  logic signed [32:0] dx_q, dy_q, dz_q;
  logic signed [DIR_W-1:0] ddx_q, ddy_q, ddz_q;
  carry_t c1_q, c2_q;
  logic [47:0] sqx_q, sqy_q, sqz_q;
  logic signed [48:0] pdx_q, pdy_q, pdz_q;
  logic [49:0] d2_q;
  logic signed [50:0] dot_q;
  logic live3_q, spot3_q;
  logic signed [COS_W-1:0] cc3_q;
  logic [RGB_W-1:0] rgb3_q;
  logic [REACH_W-1:0] reach3_q;

  logic [32:0] ax, ay, az;
  logic [63:0] sqx, sqy, sqz;
  logic [49:0] d2_d;

  a_t a_in_q;
  a_t a_q [SQRT_STEPS];
  a_t a_d [SQRT_STEPS];
  b_t b_in_q, b_in_d;
  b_t b_q [DIV_C_STEPS];
  b_t b_d [DIV_C_STEPS];
  c_t c_in_q, c_in_d;
  c_t c_q [FADE_STEPS];
  c_t c_d [FADE_STEPS];

  logic             m_live_q;
  logic [RGB_W-1:0] m_rgb_q;
  logic [14:0]      m_att_q;
  logic [28:0]      fmul;
  logic [2:0][PROD_W-1:0] prod_q;

  always_comb begin
    ax  = dx_q[32] ? (~dx_q + 33'd1) : dx_q;
    ay  = dy_q[32] ? (~dy_q + 33'd1) : dy_q;
    az  = dz_q[32] ? (~dz_q + 33'd1) : dz_q;
    sqx = 64'(ax) * 64'(ax);
    sqy = 64'(ay) * 64'(ay);
    sqz = 64'(az) * 64'(az);
    d2_d = 50'(sqx_q) + 50'(sqy_q) + 50'(sqz_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dx_q  <= {px_i[31], px_i} - {lamp_i.pos_x[31], lamp_i.pos_x};
      dy_q  <= {py_i[31], py_i} - {lamp_i.pos_y[31], lamp_i.pos_y};
      dz_q  <= {pz_i[31], pz_i} - {lamp_i.pos_z[31], lamp_i.pos_z};
      ddx_q <= lamp_i.dir_x;
      ddy_q <= lamp_i.dir_y;
      ddz_q <= lamp_i.dir_z;
      c1_q  <= '{act: act_i, reach: lamp_i.reach_sq, cc: lamp_i.cone_cos, rgb: lamp_i.rgb};

      sqx_q <= sqx[63:16];
      sqy_q <= sqy[63:16];
      sqz_q <= sqz[63:16];
      pdx_q <= 49'(dx_q) * 49'(ddx_q);
      pdy_q <= 49'(dy_q) * 49'(ddy_q);
      pdz_q <= 49'(dz_q) * 49'(ddz_q);
      c2_q  <= c1_q;

      d2_q     <= d2_d;
      dot_q    <= 51'(pdx_q) + 51'(pdy_q) + 51'(pdz_q);
      live3_q  <= c2_q.act && (d2_d < 50'(c2_q.reach));
      spot3_q  <= c2_q.cc > -16'sd16384;
      cc3_q    <= c2_q.cc;
      rgb3_q   <= c2_q.rgb;
      reach3_q <= c2_q.reach;

      a_in_q.live  <= live3_q;
      a_in_q.spot  <= spot3_q;
      a_in_q.cc    <= cc3_q;
      a_in_q.rgb   <= rgb3_q;
      a_in_q.reach <= reach3_q;
      a_in_q.arem  <= reach3_q - d2_q[39:0];
      a_in_q.aq    <= '0;
      a_in_q.sv    <= {d2_q[39:0], 16'h0000};
      a_in_q.sr    <= '0;
      a_in_q.dmag  <= dot_q[50] ? 51'(~dot_q + 51'sd1) : 51'(dot_q);
      a_in_q.dneg  <= dot_q[50];
    end
  end

  // root of d2 and falloff quotient side by side
  always_comb begin
    logic [56:0] trial;
    logic [40:0] t;
    a_t src;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (k == 0) src = a_in_q;
      else        src = a_q[k-1];
      a_d[k] = src;
      trial = src.sr + (57'd1 << (54 - 2 * k));
      if ({1'b0, src.sv} >= trial) begin
        a_d[k].sv = src.sv - trial[55:0];
        a_d[k].sr = (src.sr >> 1) + (57'd1 << (54 - 2 * k));
      end else begin
        a_d[k].sr = src.sr >> 1;
      end
      if (k < ATT_STEPS) begin
        // first step tests the top quotient bit without a shift
        t = (k == 0) ? {1'b0, src.arem} : {src.arem, 1'b0};
        if (t >= {1'b0, src.reach}) begin
          a_d[k].arem = 40'(t - {1'b0, src.reach});
          a_d[k].aq   = {src.aq[13:0], 1'b1};
        end else begin
          a_d[k].arem = t[39:0];
          a_d[k].aq   = {src.aq[13:0], 1'b0};
        end
      end
    end
  end

  // cone quotient |dot| / d, top check first
  always_comb begin
    b_in_d.live = a_q[SQRT_STEPS-1].live;
    b_in_d.spot = a_q[SQRT_STEPS-1].spot;
    b_in_d.cc   = a_q[SQRT_STEPS-1].cc;
    b_in_d.rgb  = a_q[SQRT_STEPS-1].rgb;
    b_in_d.att  = a_q[SQRT_STEPS-1].aq;
    b_in_d.d    = a_q[SQRT_STEPS-1].sr[27:0];
    b_in_d.brem = a_q[SQRT_STEPS-1].dmag;
    b_in_d.bq   = '0;
    b_in_d.sat  = a_q[SQRT_STEPS-1].dmag >= {8'h00, a_q[SQRT_STEPS-1].sr[27:0], 15'h0000};
    b_in_d.dneg = a_q[SQRT_STEPS-1].dneg;
  end

  always_comb begin
    logic [50:0] dsh;
    b_t src;
    for (int j = 0; j < DIV_C_STEPS; j++) begin
      if (j == 0) src = b_in_q;
      else        src = b_q[j-1];
      b_d[j] = src;
      dsh = 51'(src.d) << (DIV_C_STEPS - 1 - j);
      if (src.brem >= dsh) begin
        b_d[j].brem = src.brem - dsh;
        b_d[j].bq   = {src.bq[13:0], 1'b1};
      end else begin
        b_d[j].bq   = {src.bq[13:0], 1'b0};
      end
    end
  end

  // clamp cosine, cone test, fade operands
  always_comb begin
    logic [14:0] qmag;
    logic signed [16:0] cval;
    logic signed [16:0] cc17;
    b_t src;
    src  = b_q[DIV_C_STEPS-1];
    qmag = (src.sat || src.bq > UNITY) ? UNITY : src.bq;
    cval = src.dneg ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});
    cc17 = 17'(src.cc);
    c_in_d.use_cone = src.spot && (src.d != '0);
    c_in_d.live     = src.live && !(c_in_d.use_cone && (cval <= cc17));
    c_in_d.rgb      = src.rgb;
    c_in_d.att      = src.att;
    c_in_d.frem     = 16'(cval - cc17);
    c_in_d.fden     = 16'(17'sd16384 - cc17);
    c_in_d.fq       = '0;
  end

  // fade reaches one at the cone axis, so the top bit is tested unshifted
  always_comb begin
    logic [16:0] t;
    c_t src;
    for (int j = 0; j < FADE_STEPS; j++) begin
      if (j == 0) src = c_in_q;
      else        src = c_q[j-1];
      c_d[j] = src;
      t = (j == 0) ? {1'b0, src.frem} : {src.frem, 1'b0};
      if (t >= {1'b0, src.fden}) begin
        c_d[j].frem = 16'(t - {1'b0, src.fden});
        c_d[j].fq   = {src.fq[13:0], 1'b1};
      end else begin
        c_d[j].frem = t[15:0];
        c_d[j].fq   = {src.fq[13:0], 1'b0};
      end
    end
  end

  assign fmul = 29'(c_q[FADE_STEPS-1].att) * 29'(c_q[FADE_STEPS-1].fq);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_q    <= a_d;
      b_in_q <= b_in_d;
      b_q    <= b_d;
      c_in_q <= c_in_d;
      c_q    <= c_d;

      m_live_q <= c_q[FADE_STEPS-1].live;
      m_rgb_q  <= c_q[FADE_STEPS-1].rgb;
      m_att_q  <= c_q[FADE_STEPS-1].use_cone ? fmul[28:14] : c_q[FADE_STEPS-1].att;

      for (int ch = 0; ch < 3; ch++) begin
        prod_q[ch] <= m_live_q
                    ? PROD_W'(m_rgb_q[RGB_W-1-16*ch -: 16]) * PROD_W'(m_att_q)
                    : '0;
      end
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ----- rtl/particle_vertex_lighting_top.sv -----
// ----------------------------------------------------------------------------
// particle_vertex_lighting_top: particle color shading against point/spot lights
// Load transfers fill the light table; shade transfers return one lit color.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_axis    in   tuser: action; tdata: slot, position, spot dir, reach, cone,
//                 light color, particle color
//  m_axis    out  tdata: lit_color ARGB8888
//  cfg       in   cfg_we_i, cfg_idx_i, cfg_wdata_i (ambient, active count)
//
//  One transfer per cycle in both directions while the output is not held; a
//  shade result is delayed by the 28-step distance root and the two quotient
//  chains in each light lane. A load gives no result. Reset clears the valid
//  line and active count, sets the ambient to unity and leaves the light table.
//  A result held at the output freezes the whole pipeline in place.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_vertex_lighting_top (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  // [2:0] slot, [34:3] pos_x, [66:35] pos_y, [98:67] pos_z, [114:99] spot_dir_x,
  // [130:115] spot_dir_y, [146:131] spot_dir_z, [186:147] reach_sq,
  // [202:187] cone_cos, [250:203] light_rgb, [282:251] particle_color
  input  wire  [pvl_pkg::TDATA_W-1:0]     s_axis_tdata,
  // [0] action
  input  wire  [0:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  // [31:0] lit_color
  output logic [pvl_pkg::CLR_W-1:0]       m_axis_tdata,
  input  wire                             cfg_we_i,
  input  pvl_pkg::cfg_reg_e               cfg_idx_i,
  input  wire  [pvl_pkg::AMB_W-1:0]       cfg_wdata_i
);
  import pvl_pkg::*;

  logic adv;
  logic in_fire;
  logic is_load;
  lamp_t in_lamp;
  logic [SLOT_W-1:0] in_slot;
  logic [CLR_W-1:0]  in_color;

  logic [AMB_W-1:0] amb_q;
  logic [ACT_W-1:0] act_q;

  lamp_t [LAMP_SLOTS-1:0] lamps;
  logic  [LAMP_SLOTS-1:0] lane_act;
  logic  [2:0][PROD_W-1:0] lane_prod [LAMP_SLOTS];

  logic [PIPE_D-1:0] vld_q;
  logic [CLR_W-1:0]  color_q [PIPE_D];

  logic [2:0][ACC_W-1:0] acc_d, acc_q;
  logic [2:0][AMB_W-1:0] gain_d, gain_q;
  logic [CLR_W-1:0]      lit_d;

  logic                  out_valid_q;
  logic [CLR_W-1:0]      out_data_q;

  assign adv     = !out_valid_q || m_axis_tready;
  assign in_fire = s_axis_tvalid && adv;
  assign is_load = action_e'(s_axis_tuser[0]) == ACT_LOAD;

  assign in_slot        = s_axis_tdata[2:0];
  assign in_lamp.pos_x  = s_axis_tdata[34:3];
  assign in_lamp.pos_y  = s_axis_tdata[66:35];
  assign in_lamp.pos_z  = s_axis_tdata[98:67];
  assign in_lamp.dir_x  = s_axis_tdata[114:99];
  assign in_lamp.dir_y  = s_axis_tdata[130:115];
  assign in_lamp.dir_z  = s_axis_tdata[146:131];
  assign in_lamp.reach_sq = s_axis_tdata[186:147];
  assign in_lamp.cone_cos = s_axis_tdata[202:187];
  assign in_lamp.rgb    = s_axis_tdata[250:203];
  assign in_color       = s_axis_tdata[282:251];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amb_q <= UNITY;
      act_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_AMBIENT: amb_q <= cfg_wdata_i;
        CFG_ACTIVE:  act_q <= cfg_wdata_i[ACT_W-1:0];
        default:     ;
      endcase
    end
  end

  pvl_table u_table (
    .clk_i   (clk_i),
    .we_i    (in_fire && is_load),
    .slot_i  (in_slot),
    .lamp_i  (in_lamp),
    .lamps_o (lamps)
  );

  for (genvar i = 0; i < LAMP_SLOTS; i++) begin : g_lane
    assign lane_act[i] = i < int'(act_q);

    pvl_lane u_lane (
      .clk_i  (clk_i),
      .adv_i  (adv),
      .act_i  (lane_act[i]),
      .px_i   (in_lamp.pos_x),
      .py_i   (in_lamp.pos_y),
      .pz_i   (in_lamp.pos_z),
      .lamp_i (lamps[i]),
      .prod_o (lane_prod[i])
    );
  end

  // valid and color travel beside the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_D-2:0], s_axis_tvalid && !is_load};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      color_q[0] <= in_color;
      for (int i = 1; i < PIPE_D; i++) begin
        color_q[i] <= color_q[i-1];
      end
    end
  end

  always_comb begin
    logic [ACC_W-1:0] s;
    for (int ch = 0; ch < 3; ch++) begin
      s = ACC_W'({amb_q, 12'h000});
      for (int i = 0; i < LAMP_SLOTS; i++) begin
        s = s + ACC_W'(lane_prod[i][ch]);
      end
      acc_d[ch] = s;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      gain_d[ch] = (acc_q[ch][ACC_W-1:12] > (ACC_W-12)'(UNITY)) ? UNITY : acc_q[ch][26:12];
    end
  end

  always_comb begin
    logic [22:0] p;
    lit_d[31:24] = color_q[PIPE_D-1][31:24];
    lit_d[23:0]  = '0;
    for (int ch = 0; ch < 3; ch++) begin
      p = 23'(color_q[PIPE_D-1][23-8*ch -: 8]) * 23'(gain_q[ch]);
      lit_d[23-8*ch -: 8] = p[21:14];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      acc_q      <= acc_d;
      gain_q     <= gain_d;
      out_data_q <= lit_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[PIPE_D-1];
    end
  end

  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire
